// ----- src/pcde_pkg.sv -----
// Shared types, constants and helper functions for the Potts contact energy delta block.
// Depends on nothing; every other file in src uses it by scoped names.

package pcde_pkg;

   // Neighbors in one copy attempt. This bounds the accumulator range.
   localparam int NeighborCount = 26;
   localparam int TagW          = 16;
   localparam int KindW         = 2;
   localparam int EnergyW       = 16;
   localparam int DeltaW        = 22;
   localparam int CsrIndexW     = 3;

   // The accumulator saturates at plus or minus this value.
   localparam int AccLimit = NeighborCount * 65535;

   // Depth of the queue between the front and the back, and its index widths.
   localparam int FifoDepth = 4;
   localparam int FifoPtrW  = $clog2(FifoDepth);
   localparam int FifoCntW  = $clog2(FifoDepth + 1);

   localparam logic [KindW-1:0] KindCm = KindW'(1);

   typedef enum logic [CsrIndexW-1:0] {
      CSR_J_CM_CM     = 3'd0,
      CSR_J_CM_MEDIUM = 3'd1,
      CSR_J_FB_FB     = 3'd2,
      CSR_J_FB_MEDIUM = 3'd3,
      CSR_J_FB_CM     = 3'd4
   } csr_index_type;

   // Which contact energy a pair of voxels selects.
   typedef enum logic [2:0] {
      SEL_ZERO      = 3'd0,
      SEL_CM_CM     = 3'd1,
      SEL_CM_MEDIUM = 3'd2,
      SEL_FB_FB     = 3'd3,
      SEL_FB_MEDIUM = 3'd4,
      SEL_FB_CM     = 3'd5
   } energy_sel_type;

   typedef struct packed {
      energy_sel_type target_sel;
      energy_sel_type source_sel;
      logic           last;
   } fifo_entry_type;

   typedef struct packed {
      logic signed [EnergyW-1:0] cm_cm;
      logic signed [EnergyW-1:0] cm_medium;
      logic signed [EnergyW-1:0] fb_fb;
      logic signed [EnergyW-1:0] fb_medium;
      logic signed [EnergyW-1:0] fb_cm;
   } energy_table_type;

   // Classifies the contact between voxel a and voxel b.
   function automatic energy_sel_type pair_sel(
      input logic [TagW-1:0]  tag_a,
      input logic [KindW-1:0] kind_a,
      input logic [TagW-1:0]  tag_b,
      input logic [KindW-1:0] kind_b
   );
      logic [KindW-1:0] cell_kind;
      energy_sel_type   sel;
      cell_kind = (tag_a == '0) ? kind_b : kind_a;
      if (tag_a == tag_b) begin
         sel = SEL_ZERO;
      end else if (tag_a == '0 || tag_b == '0) begin
         sel = (cell_kind == KindCm) ? SEL_CM_MEDIUM : SEL_FB_MEDIUM;
      end else if (kind_a == kind_b) begin
         sel = (kind_a == KindCm) ? SEL_CM_CM : SEL_FB_FB;
      end else begin
         sel = SEL_FB_CM;
      end
      return sel;
   endfunction

   // Looks up the energy that a classification code stands for.
   function automatic logic signed [EnergyW-1:0] energy_of(
      input energy_sel_type   sel,
      input energy_table_type tbl
   );
      logic signed [EnergyW-1:0] e;
      case (sel)
         SEL_CM_CM:     e = tbl.cm_cm;
         SEL_CM_MEDIUM: e = tbl.cm_medium;
         SEL_FB_FB:     e = tbl.fb_fb;
         SEL_FB_MEDIUM: e = tbl.fb_medium;
         SEL_FB_CM:     e = tbl.fb_cm;
         default:       e = '0;
      endcase
      return e;
   endfunction

endpackage

// ----- src/pcde_front.sv -----
// Front part: accepts input words and classifies both contacts of the neighbor.
// Depends on pcde_pkg.

module pcde_front (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pcde_pkg::TagW-1:0]    req_target_tag,
   input  logic [pcde_pkg::KindW-1:0]   req_target_kind,
   input  logic [pcde_pkg::TagW-1:0]    req_source_tag,
   input  logic [pcde_pkg::KindW-1:0]   req_source_kind,
   input  logic [pcde_pkg::TagW-1:0]    req_neighbor_tag,
   input  logic [pcde_pkg::KindW-1:0]   req_neighbor_kind,
   input  logic                         req_last_neighbor,
   input  logic                         fifo_full,
   output logic                         fifo_push,
   output pcde_pkg::fifo_entry_type     fifo_wr_entry
);

   assign req_stall = fifo_full;
   assign fifo_push = req_valid && !fifo_full;

   always_comb begin
      fifo_wr_entry.target_sel = pcde_pkg::pair_sel(req_target_tag, req_target_kind,
                                                    req_neighbor_tag, req_neighbor_kind);
      fifo_wr_entry.source_sel = pcde_pkg::pair_sel(req_source_tag, req_source_kind,
                                                    req_neighbor_tag, req_neighbor_kind);
      fifo_wr_entry.last       = req_last_neighbor;
   end

endmodule

// ----- src/pcde_fifo.sv -----
// Short queue of classified words between the front and the back.
// Depends on pcde_pkg.

module pcde_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pcde_pkg::fifo_entry_type wr_entry,
   input  logic                     pop,
   output pcde_pkg::fifo_entry_type rd_entry,
   output logic                     full,
   output logic                     not_empty
);

   pcde_pkg::fifo_entry_type mem_ff [pcde_pkg::FifoDepth];

   logic [pcde_pkg::FifoPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pcde_pkg::FifoPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pcde_pkg::FifoCntW-1:0] count_ff, count_in;

   assign full      = (count_ff == pcde_pkg::FifoCntW'(pcde_pkg::FifoDepth));
   assign not_empty = (count_ff != '0);
   assign rd_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == pcde_pkg::FifoPtrW'(pcde_pkg::FifoDepth - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == pcde_pkg::FifoPtrW'(pcde_pkg::FifoDepth - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/pcde_back.sv -----
// Back part: looks up energies, accumulates the saturated delta and holds the result word.
// Depends on pcde_pkg.

module pcde_back (
   input  logic                              clock,
   input  logic                              reset,
   input  pcde_pkg::energy_table_type        energies,
   input  logic                              fifo_not_empty,
   input  pcde_pkg::fifo_entry_type          fifo_rd_entry,
   output logic                              fifo_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pcde_pkg::DeltaW-1:0] rsp_energy_delta
);

   localparam logic signed [pcde_pkg::DeltaW:0] SatHi = (pcde_pkg::DeltaW + 1)'(pcde_pkg::AccLimit);
   localparam logic signed [pcde_pkg::DeltaW:0] SatLo = -SatHi;

   logic signed [pcde_pkg::DeltaW-1:0]  acc_ff, acc_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [pcde_pkg::DeltaW-1:0]  rsp_delta_ff, rsp_delta_in;

   logic signed [pcde_pkg::EnergyW-1:0] e_target, e_source;
   logic signed [pcde_pkg::EnergyW:0]   diff;
   logic signed [pcde_pkg::DeltaW:0]    sum;
   logic signed [pcde_pkg::DeltaW-1:0]  sat;

   // A last word needs the result register free, or about to be freed.
   assign fifo_pop = fifo_not_empty &&
                     !(fifo_rd_entry.last && rsp_valid_ff && rsp_stall);

   always_comb begin
      e_target = pcde_pkg::energy_of(fifo_rd_entry.target_sel, energies);
      e_source = pcde_pkg::energy_of(fifo_rd_entry.source_sel, energies);
      diff     = {e_source[pcde_pkg::EnergyW-1], e_source}
               - {e_target[pcde_pkg::EnergyW-1], e_target};
      sum      = {acc_ff[pcde_pkg::DeltaW-1], acc_ff}
               + (pcde_pkg::DeltaW + 1)'(diff);
      if (sum > SatHi) begin
         sat = SatHi[pcde_pkg::DeltaW-1:0];
      end else if (sum < SatLo) begin
         sat = SatLo[pcde_pkg::DeltaW-1:0];
      end else begin
         sat = sum[pcde_pkg::DeltaW-1:0];
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_delta_in = rsp_delta_ff;
      if (fifo_pop) begin
         if (fifo_rd_entry.last) begin
            acc_in       = '0;
            rsp_valid_in = 1'b1;
            rsp_delta_in = sat;
         end else begin
            acc_in = sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_delta_ff <= rsp_delta_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_energy_delta = rsp_delta_ff;

endmodule

// ----- src/potts_contact_energy_delta_top.sv -----
// Top level of the Potts contact energy delta block: energy registers and the
// front, queue and back parts. Depends on pcde_pkg, pcde_front, pcde_fifo and pcde_back.
//
//   Channel  Direction  Handshake              Word
//   req      in         req_valid / req_stall  target, source and one neighbor voxel
//   rsp      out        rsp_valid / rsp_stall  energy_delta, once per copy attempt
//   csr      in         csr_wr_en              one contact energy register
//
// One request word is accepted every cycle while the four-entry queue has room.
// The result of a copy attempt reaches the output through the queue and the result
// register: the queue entry written when its last neighbor word is accepted is summed
// once it reaches the head of the queue, and lands in the result register.
// Reset is synchronous and clears the energies, the queue and the accumulator.
// A stalled result holds back only a later last-neighbor word; other words keep
// draining into the accumulator, and the queue absorbs short stalls.

module potts_contact_energy_delta_top (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pcde_pkg::TagW-1:0]           req_target_tag,
   input  logic [pcde_pkg::KindW-1:0]          req_target_kind,
   input  logic [pcde_pkg::TagW-1:0]           req_source_tag,
   input  logic [pcde_pkg::KindW-1:0]          req_source_kind,
   input  logic [pcde_pkg::TagW-1:0]           req_neighbor_tag,
   input  logic [pcde_pkg::KindW-1:0]          req_neighbor_kind,
   input  logic                                req_last_neighbor,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pcde_pkg::DeltaW-1:0]  rsp_energy_delta,

   input  logic                                csr_wr_en,
   input  logic [pcde_pkg::CsrIndexW-1:0]      csr_index,
   input  logic [pcde_pkg::EnergyW-1:0]        csr_wdata
);

   pcde_pkg::energy_table_type energies_ff, energies_in;

   logic                     fifo_push;
   logic                     fifo_pop;
   logic                     fifo_full;
   logic                     fifo_not_empty;
   pcde_pkg::fifo_entry_type fifo_wr_entry;
   pcde_pkg::fifo_entry_type fifo_rd_entry;

   // Energy registers. Writes to an index beyond the list are dropped.
   always_comb begin
      energies_in = energies_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pcde_pkg::CSR_J_CM_CM:     energies_in.cm_cm     = csr_wdata;
            pcde_pkg::CSR_J_CM_MEDIUM: energies_in.cm_medium = csr_wdata;
            pcde_pkg::CSR_J_FB_FB:     energies_in.fb_fb     = csr_wdata;
            pcde_pkg::CSR_J_FB_MEDIUM: energies_in.fb_medium = csr_wdata;
            pcde_pkg::CSR_J_FB_CM:     energies_in.fb_cm     = csr_wdata;
            default:                   energies_in = energies_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energies_ff <= '0;
      end else begin
         energies_ff <= energies_in;
      end
   end

   pcde_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_target_tag    (req_target_tag),
      .req_target_kind   (req_target_kind),
      .req_source_tag    (req_source_tag),
      .req_source_kind   (req_source_kind),
      .req_neighbor_tag  (req_neighbor_tag),
      .req_neighbor_kind (req_neighbor_kind),
      .req_last_neighbor (req_last_neighbor),
      .fifo_full         (fifo_full),
      .fifo_push         (fifo_push),
      .fifo_wr_entry     (fifo_wr_entry)
   );

   pcde_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .wr_entry  (fifo_wr_entry),
      .pop       (fifo_pop),
      .rd_entry  (fifo_rd_entry),
      .full      (fifo_full),
      .not_empty (fifo_not_empty)
   );

   pcde_back u_back (
      .clock            (clock),
      .reset            (reset),
      .energies         (energies_ff),
      .fifo_not_empty   (fifo_not_empty),
      .fifo_rd_entry    (fifo_rd_entry),
      .fifo_pop         (fifo_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_energy_delta (rsp_energy_delta)
   );

endmodule

// ----- tb/sv/potts_contact_energy_delta_top_tb.sv -----
// Self-checking testbench for potts_contact_energy_delta_top: directed and random copy attempts,
// checked word by word against a predictor of the adhesion energy sum kept in this file.
// Depends on pcde_pkg for widths, the register index enum and the accumulator limit.

module potts_contact_energy_delta_top_tb;

   // One request word: target, source and one neighbor voxel, plus the end-of-attempt mark.
   typedef struct packed {
      logic [pcde_pkg::TagW-1:0]  target_tag;
      logic [pcde_pkg::KindW-1:0] target_kind;
      logic [pcde_pkg::TagW-1:0]  source_tag;
      logic [pcde_pkg::KindW-1:0] source_kind;
      logic [pcde_pkg::TagW-1:0]  neighbor_tag;
      logic [pcde_pkg::KindW-1:0] neighbor_kind;
      logic                       last;
   } voxel_word_type;

   localparam int HoldCycles          = 80;
   localparam int PressureWords       = 40;
   localparam int RandomPhases        = 5;
   localparam int RandomWordsPerPhase = 320;
   localparam int SettleCycles        = 12;
   localparam int DrainLimit          = 20000;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [pcde_pkg::TagW-1:0]            req_target_tag = '0;
   logic [pcde_pkg::KindW-1:0]           req_target_kind = '0;
   logic [pcde_pkg::TagW-1:0]            req_source_tag = '0;
   logic [pcde_pkg::KindW-1:0]           req_source_kind = '0;
   logic [pcde_pkg::TagW-1:0]            req_neighbor_tag = '0;
   logic [pcde_pkg::KindW-1:0]           req_neighbor_kind = '0;
   logic                                 req_last_neighbor = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [pcde_pkg::DeltaW-1:0]   rsp_energy_delta;
   logic                                 csr_wr_en = 1'b0;
   logic [pcde_pkg::CsrIndexW-1:0]       csr_index = '0;
   logic [pcde_pkg::EnergyW-1:0]         csr_wdata = '0;

   // Predictor state: the contact energy registers as the block should hold them, the
   // running sum of the open copy attempt, and the deltas still owed by the block.
   logic signed [pcde_pkg::EnergyW-1:0]  energy_reg [5] = '{default: '0};
   int                                   running_delta = 0;
   logic signed [pcde_pkg::DeltaW-1:0]   expected_deltas [$];
   logic signed [pcde_pkg::DeltaW-1:0]   want;

   int  words_sent = 0;
   int  results_checked = 0;
   int  energy_settings = 0;
   int  error_count = 0;
   bit  sender_pauses = 1'b1;
   bit  stall_enable = 1'b1;
   int  hold_cycles = 0;

   potts_contact_energy_delta_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_target_tag    (req_target_tag),
      .req_target_kind   (req_target_kind),
      .req_source_tag    (req_source_tag),
      .req_source_kind   (req_source_kind),
      .req_neighbor_tag  (req_neighbor_tag),
      .req_neighbor_kind (req_neighbor_kind),
      .req_last_neighbor (req_last_neighbor),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_energy_delta  (rsp_energy_delta),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A generous fixed bound on the whole run; a hung handshake ends up here.
   initial begin
      #5_000_000;
      $display("%0t: timeout, %0d energy deltas still outstanding", $time,
               expected_deltas.size());
      $display("tb: failure");
      $finish;
   end

   // Contact energy between voxel a and voxel b under the current register values.
   // Equal tags mean the same cell (or medium against medium) and cost nothing. Against
   // the medium the cell's own kind decides; between two cells only kind equality does,
   // and kind 1 is the only kind with energies of its own.
   function automatic int contact_energy(
      input logic [pcde_pkg::TagW-1:0]  tag_a,
      input logic [pcde_pkg::KindW-1:0] kind_a,
      input logic [pcde_pkg::TagW-1:0]  tag_b,
      input logic [pcde_pkg::KindW-1:0] kind_b
   );
      logic [pcde_pkg::KindW-1:0] cell_kind;
      cell_kind = (tag_a == '0) ? kind_b : kind_a;
      if (tag_a == tag_b) begin
         return 0;
      end
      if (tag_a == '0 || tag_b == '0) begin
         return (cell_kind == pcde_pkg::KindCm) ?
                int'(energy_reg[pcde_pkg::CSR_J_CM_MEDIUM]) :
                int'(energy_reg[pcde_pkg::CSR_J_FB_MEDIUM]);
      end
      if (kind_a == kind_b) begin
         return (kind_a == pcde_pkg::KindCm) ? int'(energy_reg[pcde_pkg::CSR_J_CM_CM])
                                             : int'(energy_reg[pcde_pkg::CSR_J_FB_FB]);
      end
      return int'(energy_reg[pcde_pkg::CSR_J_FB_CM]);
   endfunction

   // Adds one accepted word to the running sum, saturating at the accumulator limit, and
   // books the delta that the block owes when the word closes the attempt.
   task automatic accumulate_word(input voxel_word_type w);
      int sum;
      sum = running_delta
            + contact_energy(w.source_tag, w.source_kind, w.neighbor_tag, w.neighbor_kind)
            - contact_energy(w.target_tag, w.target_kind, w.neighbor_tag, w.neighbor_kind);
      if (sum > pcde_pkg::AccLimit) begin
         sum = pcde_pkg::AccLimit;
      end else if (sum < -pcde_pkg::AccLimit) begin
         sum = -pcde_pkg::AccLimit;
      end
      running_delta = sum;
      if (w.last) begin
         expected_deltas.push_back(pcde_pkg::DeltaW'(sum));
         running_delta = 0;
      end
   endtask

   // Offers one word after an optional random pause and holds it until it is taken.
   // Valid stays high between back-to-back words, so it is only ever written once per
   // falling edge.
   task automatic send_word(input voxel_word_type w);
      int gap;
      gap = 0;
      if (sender_pauses && $urandom_range(0, 3) == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_target_tag    <= w.target_tag;
      req_target_kind   <= w.target_kind;
      req_source_tag    <= w.source_tag;
      req_source_kind   <= w.source_kind;
      req_neighbor_tag  <= w.neighbor_tag;
      req_neighbor_kind <= w.neighbor_kind;
      req_last_neighbor <= w.last;
      do @(posedge clock); while (req_stall);
      accumulate_word(w);
      words_sent++;
   endtask

   // Drops valid and waits until every owed delta has come back, then lets the queue and
   // the accumulator settle, since words without a last mark produce nothing to wait on.
   task automatic wait_until_idle();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_deltas.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      if (expected_deltas.size() != 0) begin
         $display("%0t: %0d expected energy deltas never arrived, oldest %0d", $time,
                  expected_deltas.size(), expected_deltas[0]);
         error_count++;
         expected_deltas.delete();
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [pcde_pkg::CsrIndexW-1:0] idx,
                                 input logic [pcde_pkg::EnergyW-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      // Indexes past the last energy register are not decoded and change nothing.
      if (idx <= pcde_pkg::CSR_J_FB_CM) begin
         energy_reg[idx] = value;
      end
   endtask

   task automatic load_energies(input logic [pcde_pkg::EnergyW-1:0] cm_cm,
                                input logic [pcde_pkg::EnergyW-1:0] cm_medium,
                                input logic [pcde_pkg::EnergyW-1:0] fb_fb,
                                input logic [pcde_pkg::EnergyW-1:0] fb_medium,
                                input logic [pcde_pkg::EnergyW-1:0] fb_cm);
      write_register(pcde_pkg::CSR_J_CM_CM, cm_cm);
      write_register(pcde_pkg::CSR_J_CM_MEDIUM, cm_medium);
      write_register(pcde_pkg::CSR_J_FB_FB, fb_fb);
      write_register(pcde_pkg::CSR_J_FB_MEDIUM, fb_medium);
      write_register(pcde_pkg::CSR_J_FB_CM, fb_cm);
      energy_settings++;
   endtask

   function automatic voxel_word_type make_word(
      input logic [pcde_pkg::TagW-1:0] t_tag, input logic [pcde_pkg::KindW-1:0] t_kind,
      input logic [pcde_pkg::TagW-1:0] s_tag, input logic [pcde_pkg::KindW-1:0] s_kind,
      input logic [pcde_pkg::TagW-1:0] n_tag, input logic [pcde_pkg::KindW-1:0] n_kind,
      input logic                      last
   );
      voxel_word_type w;
      w.target_tag    = t_tag;
      w.target_kind   = t_kind;
      w.source_tag    = s_tag;
      w.source_kind   = s_kind;
      w.neighbor_tag  = n_tag;
      w.neighbor_kind = n_kind;
      w.last          = last;
      return w;
   endfunction

   // Energies lean toward the two extremes so that large sums show up often.
   function automatic logic [pcde_pkg::EnergyW-1:0] pick_energy();
      case ($urandom_range(0, 3))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return pcde_pkg::EnergyW'($urandom);
      endcase
   endfunction

   // Tags favor the medium, the all-ones tag and a few small values so that equal tags
   // between target, source and neighbor occur often; the rest cover every bit.
   function automatic logic [pcde_pkg::TagW-1:0] pick_tag();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2, 3: return pcde_pkg::TagW'($urandom_range(1, 3));
         default: return pcde_pkg::TagW'($urandom);
      endcase
   endfunction

   function automatic voxel_word_type noise_word();
      return make_word(pick_tag(), pcde_pkg::KindW'($urandom),
                       pick_tag(), pcde_pkg::KindW'($urandom),
                       pick_tag(), pcde_pkg::KindW'($urandom), $urandom_range(0, 2) == 0);
   endfunction

   // One copy attempt: fixed target and source, a stream of neighbors, the last one
   // marked. Some attempts run past the neighbor count, and some change target or
   // source halfway, which the block must simply add up like any other word.
   task automatic send_random_attempt();
      voxel_word_type w;
      int             length;
      bit             broken;
      w = noise_word();
      length = ($urandom_range(0, 9) == 0) ?
               $urandom_range(pcde_pkg::NeighborCount + 1, 40) :
               $urandom_range(1, pcde_pkg::NeighborCount);
      broken = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < length; i++) begin
         if (broken && $urandom_range(0, 3) == 0) begin
            w.target_tag  = pick_tag();
            w.source_kind = pcde_pkg::KindW'($urandom);
         end
         case ($urandom_range(0, 4))
            0: w.neighbor_tag = w.target_tag;
            1: w.neighbor_tag = w.source_tag;
            2: w.neighbor_tag = '0;
            default: w.neighbor_tag = pick_tag();
         endcase
         w.neighbor_kind = pcde_pkg::KindW'($urandom);
         w.last = (i == length - 1);
         send_word(w);
      end
   endtask

   task automatic repeat_word(input voxel_word_type w, input int n, input bit close);
      for (int i = 0; i < n; i++) begin
         w.last = close && (i == n - 1);
         send_word(w);
      end
   endtask

   // Every contact class at least once, with distinct energies so a wrong pick cannot hide:
   // same cell, medium against medium, each cell against the medium by kind, equal and
   // differing kinds between cells (kinds 2 and 3 count as differing), the extreme tags,
   // and an attempt that stays open over several words before its last mark.
   task automatic test_contact_classes();
      load_energies(16'h0100, 16'hFE00, 16'h0380, 16'hFB40, 16'h0A10);
      // Writes to undecoded indexes must leave all five energies alone.
      for (int i = int'(pcde_pkg::CSR_J_FB_CM) + 1; i < 2 ** pcde_pkg::CsrIndexW; i++) begin
         write_register(pcde_pkg::CsrIndexW'(i), 16'h7FFF);
      end
      send_word(make_word(16'd5, pcde_pkg::KindCm, 16'd5, pcde_pkg::KindCm,
                          16'd5, pcde_pkg::KindCm, 1'b1));
      send_word(make_word('0, 2'd0, '0, 2'd2, '0, 2'd3, 1'b1));
      send_word(make_word('0, 2'd0, 16'd9, pcde_pkg::KindCm, '0, 2'd0, 1'b1));
      send_word(make_word('0, 2'd0, 16'd9, 2'd0, '0, pcde_pkg::KindCm, 1'b1));
      send_word(make_word(16'd9, 2'd2, '0, 2'd0, '0, pcde_pkg::KindCm, 1'b1));
      send_word(make_word('0, 2'd3, 16'd12, pcde_pkg::KindCm,
                          16'd12, pcde_pkg::KindCm, 1'b1));
      send_word(make_word(16'd3, pcde_pkg::KindCm, 16'd4, 2'd2,
                          16'd7, pcde_pkg::KindCm, 1'b1));
      send_word(make_word(16'd3, 2'd0, 16'd4, pcde_pkg::KindCm, 16'd7, 2'd0, 1'b1));
      send_word(make_word(16'd3, 2'd2, 16'd4, 2'd3, 16'd7, 2'd2, 1'b1));
      send_word(make_word(16'd3, 2'd3, 16'd4, 2'd2, 16'd7, 2'd3, 1'b1));
      send_word(make_word(16'hFFFF, 2'd3, 16'd1, pcde_pkg::KindCm,
                          16'hFFFF, pcde_pkg::KindCm, 1'b1));
      send_word(make_word(16'h8000, pcde_pkg::KindCm, 16'h7FFF, 2'd0, '0, 2'd2, 1'b1));
      send_word(make_word(16'd21, pcde_pkg::KindCm, 16'd22, 2'd0, '0, 2'd0, 1'b0));
      send_word(make_word(16'd21, pcde_pkg::KindCm, 16'd22, 2'd0,
                          16'd21, pcde_pkg::KindCm, 1'b0));
      send_word(make_word(16'd21, pcde_pkg::KindCm, 16'd22, 2'd0, 16'd22, 2'd0, 1'b0));
      send_word(make_word(16'd21, pcde_pkg::KindCm, 16'd22, 2'd0,
                          16'd23, pcde_pkg::KindCm, 1'b0));
      send_word(make_word(16'd21, pcde_pkg::KindCm, 16'd22, 2'd0, 16'd24, 2'd2, 1'b0));
      send_word(make_word(16'd21, pcde_pkg::KindCm, 16'd22, 2'd0, 16'd25, 2'd3, 1'b1));
      wait_until_idle();
   endtask

   // Each register at both ends of its range, then back to zero as after reset.
   task automatic test_energy_extremes();
      load_energies(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      repeat (3) send_random_attempt();
      wait_until_idle();
      load_energies(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      repeat (3) send_random_attempt();
      wait_until_idle();
      load_energies(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
      repeat (3) send_random_attempt();
      wait_until_idle();
      load_energies('0, '0, '0, '0, '0);
      repeat (3) send_random_attempt();
      wait_until_idle();
   endtask

   // A cardiomyocyte target and an other-kind source against a medium neighbor give the
   // largest step of one word in either direction. A full neighbor count lands exactly
   // on the limit; longer streams must clamp there and step back from it afterwards.
   task automatic test_saturation();
      voxel_word_type up;
      voxel_word_type down;
      load_energies('0, 16'h8000, '0, 16'h7FFF, '0);
      up   = make_word(16'd5, pcde_pkg::KindCm, 16'd7, 2'd0, '0, 2'd2, 1'b0);
      down = make_word(16'd7, 2'd0, 16'd5, pcde_pkg::KindCm, '0, 2'd3, 1'b0);
      repeat_word(up, pcde_pkg::NeighborCount, 1'b1);
      repeat_word(up, pcde_pkg::NeighborCount + 4, 1'b1);
      repeat_word(down, pcde_pkg::NeighborCount + 4, 1'b1);
      repeat_word(up, pcde_pkg::NeighborCount + 2, 1'b0);
      repeat_word(down, 1, 1'b1);
      wait_until_idle();
   endtask

   // The receiver holds off for a long counted stretch while short attempts keep coming
   // back to back, so the queue and the result register fill and the block stalls its
   // input. Every delta must still come out in order once the hold ends.
   task automatic test_result_hold();
      voxel_word_type w;
      load_energies(pick_energy(), pick_energy(), pick_energy(), pick_energy(), pick_energy());
      sender_pauses = 1'b0;
      stall_enable  = 1'b0;
      hold_cycles   = HoldCycles;
      for (int i = 0; i < PressureWords; i++) begin
         w = noise_word();
         w.last = ($urandom_range(0, 1) == 0) || (i == PressureWords - 1);
         send_word(w);
      end
      wait_until_idle();
   endtask

   // The bulk of the run: mostly well-formed attempts with random content, some stray
   // words, a fresh energy setting per phase, and one phase with no idling on either side.
   task automatic test_random_traffic();
      int phase_start;
      for (int phase = 0; phase < RandomPhases; phase++) begin
         load_energies(pick_energy(), pick_energy(), pick_energy(), pick_energy(),
                       pick_energy());
         sender_pauses = (phase != 2);
         stall_enable  = (phase != 2);
         phase_start   = words_sent;
         while (words_sent - phase_start < RandomWordsPerPhase) begin
            if ($urandom_range(0, 9) == 0) begin
               send_word(noise_word());
            end else begin
               send_random_attempt();
            end
         end
         wait_until_idle();
      end
   endtask

   // Result side stall: short random stalls, now and then a long one, and a single long
   // hold when a test asks for it, counted here in cycles.
   initial begin : rsp_stall_driver
      int run;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (stall_enable && $urandom_range(0, 3) == 0) begin
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (run) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every result word taken by the receiver is matched against the oldest owed delta.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_deltas.size() == 0) begin
            $display("%0t: energy_delta %0d arrived with no copy attempt closed", $time,
                     rsp_energy_delta);
            error_count++;
         end else begin
            want = expected_deltas.pop_front();
            if (rsp_energy_delta !== want) begin
               $display("%0t: energy_delta expected %0d, got %0d", $time, want,
                        rsp_energy_delta);
               error_count++;
            end
            results_checked++;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_contact_classes();
      test_energy_extremes();
      test_saturation();
      test_result_hold();
      test_random_traffic();
      $display("ran %0d request words, %0d energy deltas compared, %0d energy settings",
               words_sent, results_checked, energy_settings);
      $display("covered every contact class, kinds 0 to 3, both saturation limits, open");
      $display("attempts and a %0d-cycle result hold with the input stalled", HoldCycles);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
